// ----- hdl/gbs_pkg.sv -----
// Package for greedy box suppression: field widths, defaults, FSM state type.
// No dependencies.
`default_nettype none
package gbs_pkg;
  localparam int unsigned MaxKeptDef  = 64;
  localparam int unsigned MaxBoxesDef = 1024;
  localparam logic [15:0] IouThrReset = 16'd29491;
  localparam int unsigned CoordW = 16;
  localparam int unsigned AreaW  = 30;
  localparam int unsigned IdxW   = 10;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL, ST_CMP, ST_DONE
  } gbs_state_t;
endpackage
`default_nettype wire

// ----- hdl/greedy_box_suppression.sv -----
// Greedy box suppression, top level.
// Uses gbs_pkg; kept boxes live in two synchronous memories inside this module.
//
// Boxes enter in descending score order, one item per set member; each item
// yields one result item. An item is handled in these steps: an accept, then a
// memory read, a multiply stage and a compare for each stored box, one last read
// that ends the scan, and a step to issue the result. The block takes no new item
// before it is through with the last one. All of it runs in sequence through the
// single read port of the kept-box memories, and a result that waits for m_tready
// stalls the next item's issue step until it is taken. The store needs no
// clearing pass; a fill count tracks its valid entries.
`default_nettype none
module greedy_box_suppression #(
  parameter int unsigned MAX_KEPT  = gbs_pkg::MaxKeptDef,
  parameter int unsigned MAX_BOXES = gbs_pkg::MaxBoxesDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: box_left[15:0], box_top[31:16], box_width[46:32], box_height[61:47]
  input  wire logic [63:0] s_tdata,
  input  wire logic        s_tlast,   // set_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: keep[0], box_index[10:1], store_full[11]
  output logic [15:0]      m_tdata,
  output logic             m_tlast    // set_done
);
  import gbs_pkg::*;

  localparam int unsigned KW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CW  = $clog2(MAX_KEPT + 1);
  localparam int unsigned PW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  logic [15:0] iou_thr;
  always_ff @(posedge clk) begin
    if (rst) iou_thr <= IouThrReset;
    else if (cfg_we) iou_thr <= cfg_wdata;
  end

  // kept-box memories
  logic [63:0]      mem_corners [MAX_KEPT];
  logic [AreaW-1:0] mem_areas   [MAX_KEPT];
  logic [63:0]      rd_corners;
  logic [AreaW-1:0] rd_area;
  logic             mem_we;
  logic [KW-1:0]    rd_addr;

  gbs_state_t state, state_next;
  logic [CW-1:0] kept_count, scan;
  logic [PW-1:0] set_pos;
  logic signed [16:0] cl, ct, cr, cb;
  logic [AreaW-1:0] carea;
  logic cur_last, keep_r;
  logic [16:0] ow, oh;
  logic [33:0] inter;
  logic [AreaW:0] area_sum;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_corners[kept_count[KW-1:0]] <= {cl[15:0], ct[15:0], cr[15:0], cb[15:0]};
      mem_areas[kept_count[KW-1:0]]   <= carea;
    end
    rd_corners <= mem_corners[rd_addr];
    rd_area    <= mem_areas[rd_addr];
  end
  assign rd_addr = scan[KW-1:0];

  // overlap lengths of the read entry
  logic signed [16:0] kl, kt, kr, kb, lo_x, hi_x, lo_y, hi_y;
  always_comb begin
    kl = 17'(signed'(rd_corners[63:48]));
    kt = 17'(signed'(rd_corners[47:32]));
    kr = 17'(signed'(rd_corners[31:16]));
    kb = 17'(signed'(rd_corners[15:0]));
    lo_x = (cl > kl) ? cl : kl;
    hi_x = (cr < kr) ? cr : kr;
    lo_y = (ct > kt) ? ct : kt;
    hi_y = (cb < kb) ? cb : kb;
    ow = (hi_x > lo_x) ? 17'(hi_x - lo_x) : 17'd0;
    oh = (hi_y > lo_y) ? 17'(hi_y - lo_y) : 17'd0;
  end

  // union and overlap test
  logic [AreaW+1:0] uni;
  logic [49:0] lhs, rhs;
  always_comb begin
    uni = {1'b0, area_sum} - {1'b0, inter[AreaW:0]};
    lhs = {inter, 16'd0};
    rhs = 50'(uni) * 50'(iou_thr);
  end

  // input edge and area arithmetic
  logic signed [16:0] in_l, in_t, in_r, in_b;
  always_comb begin
    in_l = 17'(signed'(s_tdata[15:0]));
    in_t = 17'(signed'(s_tdata[31:16]));
    in_r = in_l + 17'({2'b0, s_tdata[46:32]});
    in_b = in_t + 17'({2'b0, s_tdata[61:47]});
    if (in_r > 17'sd32767) in_r = 17'sd32767;
    if (in_b > 17'sd32767) in_b = 17'sd32767;
  end

  assign s_tready = (state == ST_IDLE);
  assign mem_we = (state == ST_DONE) && !m_tvalid && keep_r &&
                  (kept_count < CW'(MAX_KEPT));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_READ;
      ST_READ: state_next = (scan < kept_count) ? ST_MUL : ST_DONE;
      ST_MUL:  state_next = ST_CMP;
      ST_CMP:  state_next = ST_READ;
      ST_DONE: if (!m_tvalid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      set_pos    <= '0;
      m_tvalid   <= 1'b0;
      scan       <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_tvalid) begin
          cl <= in_l; ct <= in_t; cr <= in_r; cb <= in_b;
          carea <= AreaW'(17'(in_r - in_l) * 17'(in_b - in_t));
          cur_last <= s_tlast;
          keep_r <= 1'b1;
          scan <= '0;
        end
        ST_READ: ;
        ST_MUL: begin
          inter <= ow * oh;
          area_sum <= {1'b0, carea} + {1'b0, rd_area};
        end
        ST_CMP: begin
          if (uni != '0 && lhs > rhs) keep_r <= 1'b0;
          scan <= scan + 1'b1;
        end
        ST_DONE: if (!m_tvalid) begin
          m_tvalid <= 1'b1;
          m_tdata <= {4'd0,
                      keep_r && (kept_count >= CW'(MAX_KEPT)),
                      IdxW'(set_pos), keep_r};
          m_tlast <= cur_last;
          if (cur_last) begin
            kept_count <= '0;
            set_pos <= '0;
          end else begin
            if (mem_we) kept_count <= kept_count + 1'b1;
            set_pos <= (32'(set_pos) + 1 >= MAX_BOXES) ? '0 : set_pos + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
